@@ rtl/core/rbi_pkg.sv @@
// Shared types and timing constants for the RGB LED blink indicator.
// Used by the register file, the indicator core and the top level.
// No dependencies.
`default_nettype none

package rbi_pkg;

   // Timing in one millisecond ticks.
   localparam logic [7:0] BLINK_OFF_TICKS = 8'd200;
   localparam logic [7:0] BLINK_ON_TICKS  = 8'd100;
   localparam logic [4:0] UPDATE_TICKS    = 5'd20;
   localparam logic [5:0] PULSE_STEPS     = 6'd50;
   localparam logic [5:0] PULSE_HALF      = PULSE_STEPS / 6'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_OVERRIDE_ENABLE = 2'd0,
      REG_OVERRIDE_RED    = 2'd1,
      REG_OVERRIDE_GREEN  = 2'd2,
      REG_OVERRIDE_BLUE   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic       override_enable;
      logic [7:0] override_red;
      logic [7:0] override_green;
      logic [7:0] override_blue;
   } cfg_type;

   typedef struct packed {
      logic red_on;
      logic green_on;
      logic blue_on;
      logic indicating;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/rgb_led_blink_indicator.sv @@
// A taken beat is held in the input registers, then its result in the result register.
// One beat per cycle unless rsp_* stalls; input and result registers each hold one beat.
// The indicator state advances once per beat, so beats may follow back to back.
// Reset is synchronous, active high: it clears valids, the indicator state and the CSRs.
`default_nettype none

module rgb_led_blink_indicator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_func,
   input  wire logic                            req_connected,
   input  wire logic [3:0]                      req_profile_num,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_red_on,
   output logic                                 rsp_green_on,
   output logic                                 rsp_blue_on,
   output logic                                 rsp_indicating,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rbi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rbi_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rbi_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import rbi_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       func_ff, connected_ff;
   logic [3:0] index_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       advance;
   logic       req_take;

   assign csr_pready = 1'b1;

   rbi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // The held beat moves on whenever the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   rbi_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .func        (func_ff),
      .connected   (connected_ff),
      .profile_num (index_ff),
      .cfg         (cfg),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff      <= req_func;
         connected_ff <= req_connected;
         index_ff     <= req_profile_num;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_on     = rsp_ff.red_on;
   assign rsp_green_on   = rsp_ff.green_on;
   assign rsp_blue_on    = rsp_ff.blue_on;
   assign rsp_indicating = rsp_ff.indicating;

endmodule

`default_nettype wire

@@ rtl/core/rbi_csr.sv @@
// Configuration register file behind an APB-style port.
// Holds the override enable and the override colour levels.
// Depends on rbi_pkg.
`default_nettype none

module rbi_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rbi_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rbi_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [rbi_pkg::CSR_DATA_W-1:0]  prdata,
   output rbi_pkg::cfg_type                     cfg
);
   import rbi_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_OVERRIDE_ENABLE: cfg_in.override_enable = pwdata[0];
            REG_OVERRIDE_RED:    cfg_in.override_red    = pwdata[7:0];
            REG_OVERRIDE_GREEN:  cfg_in.override_green  = pwdata[7:0];
            REG_OVERRIDE_BLUE:   cfg_in.override_blue   = pwdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         REG_OVERRIDE_ENABLE: prdata[0]   = cfg_ff.override_enable;
         REG_OVERRIDE_RED:    prdata[7:0] = cfg_ff.override_red;
         REG_OVERRIDE_GREEN:  prdata[7:0] = cfg_ff.override_green;
         REG_OVERRIDE_BLUE:   prdata[7:0] = cfg_ff.override_blue;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/rbi_core.sv @@
// Indicator state machine: blink sequencing, periodic refresh and pulse pattern.
// Computes the next state and the result of one beat combinationally.
// Depends on rbi_pkg.
`default_nettype none

module rbi_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                func,
   input  wire logic                connected,
   input  wire logic [3:0]          profile_num,
   input  rbi_pkg::cfg_type         cfg,
   output rbi_pkg::result_type      result
);
   import rbi_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_ON   = 2'd1,
      MODE_OFF  = 2'd2
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [4:0] blinks_left_ff, blinks_left_in;
   logic [7:0] phase_ff, phase_in;
   logic [4:0] since_ff, since_in;
   logic [5:0] pulse_ff, pulse_in;
   logic [2:0] led_ff, led_in;

   logic [7:0] phase_inc;
   logic [4:0] since_inc;
   logic [6:0] pulse_sum;
   logic [5:0] pulse_wrap;
   logic [2:0] override_led;

   // Both elapsed counters saturate instead of wrapping.
   assign phase_inc    = (phase_ff == 8'hFF) ? phase_ff : phase_ff + 8'd1;
   assign since_inc    = (since_ff == 5'h1F) ? since_ff : since_ff + 5'd1;
   assign pulse_sum    = {1'b0, pulse_ff} + 7'd1;
   assign pulse_wrap   = (pulse_sum >= {1'b0, PULSE_STEPS}) ? 6'd0 : pulse_sum[5:0];
   assign override_led = {|cfg.override_red, |cfg.override_green, |cfg.override_blue};

   always_comb begin
      mode_in        = mode_ff;
      blinks_left_in = blinks_left_ff;
      phase_in       = phase_ff;
      since_in       = since_ff;
      pulse_in       = pulse_ff;
      led_in         = led_ff;
      if (!func) begin
         phase_in = phase_inc;
         since_in = since_inc;
         unique case (mode_ff)
            MODE_OFF: begin
               led_in = 3'b000;
               if (phase_inc >= BLINK_OFF_TICKS) begin
                  blinks_left_in = blinks_left_ff - 5'd1;
                  mode_in        = (blinks_left_in != 5'd0) ? MODE_ON : MODE_IDLE;
                  phase_in       = 8'd0;
               end
            end
            MODE_ON: begin
               led_in = cfg.override_enable ? override_led : 3'b111;
               if (phase_inc >= BLINK_ON_TICKS) begin
                  mode_in  = MODE_OFF;
                  phase_in = 8'd0;
               end
            end
            MODE_IDLE: begin
               if (since_inc >= UPDATE_TICKS) begin
                  since_in = 5'd0;
                  pulse_in = pulse_wrap;
                  if (connected || (pulse_wrap < PULSE_HALF)) begin
                     led_in = cfg.override_enable ? override_led : 3'b001;
                  end else begin
                     led_in = 3'b000;
                  end
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
      end else if (mode_ff == MODE_IDLE) begin
         // A request is taken only while idle; the LEDs change on the next tick.
         blinks_left_in = {1'b0, profile_num} + 5'd1;
         mode_in        = MODE_OFF;
         phase_in       = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         blinks_left_ff <= '0;
         phase_ff       <= '0;
         since_ff       <= '0;
         pulse_ff       <= '0;
         led_ff         <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         blinks_left_ff <= blinks_left_in;
         phase_ff       <= phase_in;
         since_ff       <= since_in;
         pulse_ff       <= pulse_in;
         led_ff         <= led_in;
      end
   end

   assign result.red_on     = led_in[2];
   assign result.green_on   = led_in[1];
   assign result.blue_on    = led_in[0];
   assign result.indicating = (mode_in != MODE_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/rbi_checker.sv @@
// Port-level checks for the RGB LED blink indicator, bound to the top level.
// Depends on rgb_led_blink_indicator and rbi_pkg.
`default_nettype none

module rbi_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_red_on,
   input wire logic                            rsp_green_on,
   input wire logic                            rsp_blue_on,
   input wire logic                            rsp_indicating,
   input wire logic                            csr_psel,
   input wire logic                            csr_penable,
   input wire logic                            csr_pwrite,
   input wire logic [rbi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input wire logic [rbi_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input wire logic [rbi_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input wire logic                            csr_pready
);
   import rbi_pkg::*;

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_on) &&
         $stable(rsp_green_on) && $stable(rsp_blue_on) && $stable(rsp_indicating))
      else $error("stalled result beat changed");

   // The input side only stalls when the result side is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without back pressure");

   // A red level written is read back in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
         csr_paddr == {REG_OVERRIDE_RED, 2'b00}) ##1
      (csr_psel && !csr_pwrite && csr_paddr == {REG_OVERRIDE_RED, 2'b00})
      |-> csr_prdata[7:0] == $past(csr_pwdata[7:0]))
      else $error("override red readback mismatch");

endmodule

bind rgb_led_blink_indicator rbi_checker u_rbi_checker (.*);

`default_nettype wire
